// ===== rtl/tkm_pkg.sv =====
// shared types, constants and codes for the trie keyword matcher
`timescale 1ns / 1ps

package tkm_pkg;

    localparam int NODES_DEF   = 256;
    localparam int LEN_MAX_DEF = 4095;

    localparam int CH_W       = 8;
    localparam int LEN_W      = 12;
    localparam int POS_W      = 16;
    localparam int SPAN_EXT_W = 16;

    localparam logic [LEN_W-1:0] LEN_SAT = '1;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_LOOKUP  = 1'b1;
    localparam logic RESP_LOOKUP = 1'b0;
    localparam logic RESP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic has_result;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/trie_keyword_matcher.sv =====
// Byte-wide trie keyword matcher. Each accepted byte is handled one at a time: the
// transfer cycle reads the child entry for the current node and byte from the
// child table ram, and the next cycle updates the walk and writes any new child
// or terminal mark; a byte that yields an answer waits further while the
// previous answer is still held by a stalled output. After reset the child
// table is swept to zero, one entry per cycle, NODES * 256 entries (65536 at the
// default size), with the input stalled. Insert bytes (req_type 0) build the
// trie and report a status on their last byte; lookup bytes (req_type 1) give
// one answer per session, and later bytes up to last are absorbed silently.
`timescale 1ns / 1ps

module trie_keyword_matcher import tkm_pkg::*; #(
    parameter int NODES   = NODES_DEF,
    parameter int LEN_MAX = LEN_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_req_type,
    input  logic [CH_W-1:0]  i_ch,
    input  logic             i_last,
    input  logic [POS_W-1:0] i_start_pos,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_resp_kind,
    output logic             o_matched,
    output logic [LEN_W-1:0] o_match_len,
    output logic [POS_W-1:0] o_echo_start,
    output logic             o_insert_full
);

    t_cmd  cmd;
    t_stat stat;

    tkm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    tkm_dp #(
        .NODES   (NODES),
        .LEN_MAX (LEN_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_ch          (i_ch),
        .i_last        (i_last),
        .i_start_pos   (i_start_pos),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_resp_kind   (o_resp_kind),
        .o_matched     (o_matched),
        .o_match_len   (o_match_len),
        .o_echo_start  (o_echo_start),
        .o_insert_full (o_insert_full)
    );

endmodule

// ===== rtl/tkm_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tkm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tkm_ctrl.sv =====
// sequencer: table clear after reset, byte accept, child read, commit
`timescale 1ns / 1ps

module tkm_ctrl import tkm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.has_result || i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = !i_stat.clear_done;
            end
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = !i_stat.has_result || i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/tkm_dp.sv =====
// datapath: child table, walk state, session counters and result register
`timescale 1ns / 1ps

module tkm_dp import tkm_pkg::*; #(
    parameter int NODES   = NODES_DEF,
    parameter int LEN_MAX = LEN_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_req_type,
    input  logic [CH_W-1:0]  i_ch,
    input  logic             i_last,
    input  logic [POS_W-1:0] i_start_pos,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_resp_kind,
    output logic             o_matched,
    output logic [LEN_W-1:0] o_match_len,
    output logic [POS_W-1:0] o_echo_start,
    output logic             o_insert_full
);

    localparam int NB    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AW    = NB + CH_W;
    localparam int DEPTH = NODES * (2 ** CH_W);
    localparam int SW    = $clog2(LEN_MAX + 1);
    localparam int EW    = NB + 1;

    localparam logic [NB:0]   USED_FULL = (NB + 1)'(NODES);
    localparam logic [AW:0]   CLR_END   = (AW + 1)'(DEPTH);
    localparam logic [SW-1:0] SPAN_TOP  = SW'(LEN_MAX);

    // walk and session state
    logic [NB-1:0]    r_cur,   n_cur;
    logic [NB:0]      r_used,  n_used;
    logic [SW-1:0]    r_span,  n_span;
    logic             r_done,  n_done;
    logic             r_fail,  n_fail;
    logic [POS_W-1:0] r_saved, n_saved;
    logic [AW:0]      r_clr;

    // held item
    logic             r_kind;
    logic [CH_W-1:0]  r_ch;
    logic             r_last;
    logic [POS_W-1:0] r_pos;

    // result register
    logic             r_ovalid;
    logic             r_okind;
    logic             r_omatch;
    logic [LEN_W-1:0] r_olen;
    logic [POS_W-1:0] r_oecho;
    logic             r_ofull;

    // table entry: terminal mark of the child in the top bit, child index below
    logic [EW-1:0]    ram_rdata;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [NB-1:0]    ent_child;
    logic             ent_term;

    logic             wr_en;
    logic [EW-1:0]    wr_data;
    logic             res;
    logic             res_kind;
    logic             res_match;
    logic [LEN_W-1:0] res_len;
    logic [POS_W-1:0] res_echo;
    logic             res_full;
    logic             end_sess;
    logic [SW-1:0]    span_new;
    logic [SPAN_EXT_W-1:0] span_ext;
    logic             out_free;

    assign ent_child = ram_rdata[NB-1:0];
    assign ent_term  = ram_rdata[NB];
    assign span_new  = (r_span < SPAN_TOP) ? r_span + 1'b1 : r_span;
    assign span_ext  = SPAN_EXT_W'(span_new);

    always_comb begin
        n_cur     = r_cur;
        n_used    = r_used;
        n_span    = r_span;
        n_done    = r_done;
        n_fail    = r_fail;
        n_saved   = r_saved;
        wr_en     = 1'b0;
        wr_data   = '0;
        res       = 1'b0;
        res_kind  = RESP_LOOKUP;
        res_match = 1'b0;
        res_len   = '0;
        res_echo  = '0;
        res_full  = 1'b0;
        end_sess  = 1'b0;
        if (r_kind == REQ_INSERT) begin
            if (!r_fail) begin
                if (ent_child == '0) begin
                    if (r_used < USED_FULL) begin
                        n_cur   = r_used[NB-1:0];
                        n_used  = r_used + 1'b1;
                        wr_en   = 1'b1;
                        wr_data = {r_last, r_used[NB-1:0]};
                    end else begin
                        n_fail = 1'b1;
                    end
                end else begin
                    n_cur = ent_child;
                    if (r_last) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, ent_child};
                    end
                end
            end
            if (r_last) begin
                res      = 1'b1;
                res_kind = RESP_INSERT;
                res_full = n_fail;
                end_sess = 1'b1;
            end
        end else if (r_done) begin
            // answer already given: absorb until the last byte
            end_sess = r_last;
        end else begin
            n_saved = (r_span == '0) ? r_pos : r_saved;
            n_span  = span_new;
            if (ent_child == '0) begin
                res = 1'b1;
            end else begin
                n_cur     = ent_child;
                res_match = ent_term;
                res       = ent_term | r_last;
            end
            if (res) begin
                res_len  = (span_ext > SPAN_EXT_W'(LEN_SAT)) ? LEN_SAT : span_ext[LEN_W-1:0];
                res_echo = n_saved;
                if (r_last) begin
                    end_sess = 1'b1;
                end else begin
                    n_done = 1'b1;
                end
            end
        end
        if (end_sess) begin
            n_cur  = '0;
            n_span = '0;
            n_done = 1'b0;
            n_fail = 1'b0;
        end
    end

    assign out_free = !r_ovalid || !i_stall;

    assign o_stat.clear_done = (r_clr == CLR_END);
    assign o_stat.has_result = res;
    assign o_stat.out_free   = out_free;

    // clear sweep owns the write port until it finishes
    assign ram_we    = i_cmd.clr_step || (i_cmd.commit && wr_en);
    assign ram_waddr = i_cmd.clr_step ? r_clr[AW-1:0] : {r_cur, r_ch};
    assign ram_wdata = i_cmd.clr_step ? '0 : wr_data;

    tkm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr ({r_cur, i_ch}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_used   <= (NB + 1)'(1);
            r_span   <= '0;
            r_done   <= 1'b0;
            r_fail   <= 1'b0;
            r_saved  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_cur   <= n_cur;
                r_used  <= n_used;
                r_span  <= n_span;
                r_done  <= n_done;
                r_fail  <= n_fail;
                r_saved <= n_saved;
            end
            if (i_cmd.commit && res) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_req_type;
            r_ch   <= i_ch;
            r_last <= i_last;
            r_pos  <= i_start_pos;
        end
        if (i_cmd.commit && res) begin
            r_okind  <= res_kind;
            r_omatch <= res_match;
            r_olen   <= res_len;
            r_oecho  <= res_echo;
            r_ofull  <= res_full;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_resp_kind   = r_okind;
    assign o_matched     = r_omatch;
    assign o_match_len   = r_olen;
    assign o_echo_start  = r_oecho;
    assign o_insert_full = r_ofull;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && res) |-> out_free)
        else $error("pending result overwritten");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_used == $past(r_used) || r_used == $past(r_used) + 1'b1))
        else $error("node count moved by more than one");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_used <= USED_FULL && r_used != '0))
        else $error("node count out of range");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (r_clr == CLR_END))
        else $error("item accepted before table clear finished");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_step, i_cmd.accept, i_cmd.commit}))
        else $error("conflicting datapath commands");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the trie keyword matcher
`timescale 1ns / 1ps

module testbench import tkm_pkg::*; ();

    localparam int RANDOM_ITEMS   = 700;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 4 * NODES_DEF * 256;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 400;

    localparam int MODE_FREE   = 0;
    localparam int MODE_LIGHT  = 1;
    localparam int MODE_HEAVY  = 2;
    localparam int MODE_TOGGLE = 3;

    typedef struct packed {
        logic             req_type;
        logic [CH_W-1:0]  ch;
        logic             last;
        logic [POS_W-1:0] start_pos;
    } t_byte_item;

    typedef struct packed {
        logic             kind;
        logic             matched;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] echo;
        logic             full;
    } t_answer;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             i_req_type  = REQ_INSERT;
    logic [CH_W-1:0]  i_ch        = '0;
    logic             i_last      = 1'b0;
    logic [POS_W-1:0] i_start_pos = '0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_resp_kind;
    logic             o_matched;
    logic [LEN_W-1:0] o_match_len;
    logic [POS_W-1:0] o_echo_start;
    logic             o_insert_full;

    trie_keyword_matcher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .i_start_pos  (i_start_pos),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_resp_kind  (o_resp_kind),
        .o_matched    (o_matched),
        .o_match_len  (o_match_len),
        .o_echo_start (o_echo_start),
        .o_insert_full(o_insert_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    t_byte_item byte_q [$];
    t_answer    answer_q [$];
    int         mismatches = 0;

    // trie shadow state
    logic [7:0]       child_tab [0:65535];
    logic             term_mark [0:NODES_DEF-1];
    logic [8:0]       nodes_used;
    logic [7:0]       walk_node;
    logic [LEN_W-1:0] span;
    logic             hit_done;
    logic             ins_failed;
    logic [POS_W-1:0] saved_pos;

    task automatic close_session();
        walk_node  = '0;
        span       = '0;
        hit_done   = 1'b0;
        ins_failed = 1'b0;
    endtask

    // advance the trie walk by one byte, queue the answer it produces if any
    task automatic trie_walk(input t_byte_item it);
        logic [7:0] nxt;
        t_answer    a;
        bit         give;
        give = 0;
        a    = '0;
        if (it.req_type == REQ_INSERT) begin
            if (!ins_failed) begin
                nxt = child_tab[{walk_node, it.ch}];
                if (nxt == 0) begin
                    if (nodes_used < NODES_DEF) begin
                        nxt = nodes_used[7:0];
                        child_tab[{walk_node, it.ch}] = nxt;
                        nodes_used = nodes_used + 1;
                        walk_node = nxt;
                    end else begin
                        ins_failed = 1'b1;
                    end
                end else begin
                    walk_node = nxt;
                end
            end
            if (it.last) begin
                if (!ins_failed)
                    term_mark[walk_node] = 1'b1;
                a.kind = RESP_INSERT;
                a.full = ins_failed;
                give   = 1;
                close_session();
            end
        end else if (hit_done) begin
            // absorbed until the end of the text
            if (it.last)
                close_session();
        end else begin
            if (span == 0)
                saved_pos = it.start_pos;
            if (span < LEN_MAX_DEF)
                span = span + 1;
            nxt = child_tab[{walk_node, it.ch}];
            if (nxt != 0)
                walk_node = nxt;
            if (nxt == 0 || term_mark[nxt] || it.last) begin
                a.kind    = RESP_LOOKUP;
                a.matched = (nxt != 0) && term_mark[nxt];
                a.len     = span;
                a.echo    = saved_pos;
                give      = 1;
                if (it.last)
                    close_session();
                else
                    hit_done = 1'b1;
            end
        end
        if (give)
            answer_q.insert(answer_q.size(), a);
    endtask

    // ---------------- stimulus building ----------------
    logic [7:0] word_buf [0:31];
    int         word_n;
    logic [7:0] kw_mem [0:1023][0:15];
    int         kw_len [0:1023];
    int         kw_cnt = 0;

    task automatic put(input logic kind, input logic [7:0] c, input logic lst,
                       input logic [15:0] pos);
        t_byte_item it;
        it.req_type  = kind;
        it.ch        = c;
        it.last      = lst;
        it.start_pos = pos;
        byte_q.insert(byte_q.size(), it);
    endtask

    // four times in ten a tiny alphabet so words share prefixes
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 4)
            return 8'h61 + 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_word(input logic kind, input bit noisy);
        logic k_req;
        for (int k = 0; k < word_n; k++) begin
            k_req = kind;
            if (noisy && $urandom_range(0, 24) == 0)
                k_req = ~kind;
            put(k_req, word_buf[k], k == word_n - 1, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic remember_word();
        if (word_n <= 16 && kw_cnt < 1024) begin
            for (int k = 0; k < word_n; k++)
                kw_mem[kw_cnt][k] = word_buf[k];
            kw_len[kw_cnt] = word_n;
            kw_cnt++;
        end
    endtask

    task automatic load_known();
        int idx;
        idx    = $urandom_range(0, kw_cnt - 1);
        word_n = kw_len[idx];
        for (int k = 0; k < word_n; k++)
            word_buf[k] = kw_mem[idx][k];
    endtask

    // ---------------- driver ----------------
    t_byte_item drv_item;
    bit         holding    = 0;
    int         gap_left   = 0;
    int         burst_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holding = 0;
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                trie_walk(drv_item);
                holding = 0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_q.size() > 0) begin
                    drv_item = byte_q.pop_front();
                    holding  = 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_valid     <= holding;
            i_req_type  <= drv_item.req_type;
            i_ch        <= drv_item.ch;
            i_last      <= drv_item.last;
            i_start_pos <= drv_item.start_pos;
        end
    end

    // ---------------- monitor and receiver stalls ----------------
    int  answers_seen = 0;
    int  hold_left    = 0;
    bit  hold_done    = 0;
    int  stall_mode   = MODE_FREE;
    int  mode_left    = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        logic    stall_nx;
        if (i_rst_n && o_valid && !i_stall) begin
            answers_seen++;
            if (answer_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual kind %0h len %0h",
                         $time, o_resp_kind, o_match_len);
                mismatches++;
            end else begin
                a = answer_q.pop_front();
                check_field("resp_kind", a.kind, o_resp_kind);
                check_field("matched", a.matched, o_matched);
                check_field("match_len", a.len, o_match_len);
                check_field("echo_start", a.echo, o_echo_start);
                check_field("insert_full", a.full, o_insert_full);
            end
        end
        // one long hold-off so the block backs up into its input
        if (!hold_done && answers_seen == HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_nx = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(MODE_FREE, MODE_TOGGLE);
                mode_left  = $urandom_range(16, 120);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                MODE_FREE:  stall_nx = 1'b0;
                MODE_LIGHT: stall_nx = ($urandom_range(0, 3) == 0);
                MODE_HEAVY: stall_nx = ($urandom_range(0, 99) < 70);
                default:    stall_nx = ~i_stall;
            endcase
        end
        i_stall <= stall_nx;
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("trie_keyword_matcher test failed");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        int n_directed;
        int sel;
        int extra;
        foreach (child_tab[k])
            child_tab[k] = '0;
        foreach (term_mark[k])
            term_mark[k] = 1'b0;
        nodes_used = 9'd1;
        saved_pos  = '0;
        close_session();

        // directed: empty trie miss, prefix keyword, absorbed tail, extremes, mixed kinds
        put(REQ_LOOKUP, 8'h78, 1'b1, 16'h0000);
        put(REQ_INSERT, 8'h61, 1'b0, 16'h0000);
        put(REQ_INSERT, 8'h62, 1'b1, 16'h0000);
        put(REQ_INSERT, 8'h61, 1'b1, 16'hFFFF);
        put(REQ_LOOKUP, 8'h61, 1'b0, 16'hFFFF);
        put(REQ_LOOKUP, 8'h62, 1'b0, 16'h0001);
        put(REQ_LOOKUP, 8'h63, 1'b1, 16'h0002);
        put(REQ_INSERT, 8'h61, 1'b0, 16'h0000);
        put(REQ_INSERT, 8'h62, 1'b1, 16'h0000);
        put(REQ_LOOKUP, 8'h7A, 1'b0, 16'h5555);
        put(REQ_LOOKUP, 8'h71, 1'b1, 16'hAAAA);
        put(REQ_INSERT, 8'hFF, 1'b0, 16'h0000);
        put(REQ_INSERT, 8'h00, 1'b1, 16'h0000);
        put(REQ_LOOKUP, 8'hFF, 1'b0, 16'h1234);
        put(REQ_LOOKUP, 8'h00, 1'b1, 16'h0000);
        put(REQ_LOOKUP, 8'hFF, 1'b1, 16'hFFFF);
        put(REQ_INSERT, 8'h63, 1'b0, 16'h0000);
        put(REQ_LOOKUP, 8'h64, 1'b1, 16'h0F0F);
        put(REQ_INSERT, 8'h00, 1'b1, 16'h0000);
        put(REQ_LOOKUP, 8'h00, 1'b0, 16'h8000);
        put(REQ_LOOKUP, 8'hFF, 1'b1, 16'h7FFF);
        n_directed = byte_q.size();

        // random sessions; long random keywords push the node table toward running out
        while (byte_q.size() < n_directed + RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                word_n = $urandom_range(8, 14);
                for (int k = 0; k < word_n; k++)
                    word_buf[k] = 8'($urandom_range(0, 255));
                queue_word(REQ_INSERT, 0);
                remember_word();
            end else if (sel < 25 && kw_cnt > 0) begin
                load_known();
                queue_word(REQ_INSERT, 0);
            end else if (sel < 45) begin
                word_n = $urandom_range(1, 6);
                for (int k = 0; k < word_n; k++)
                    word_buf[k] = pick_char();
                queue_word(REQ_INSERT, 0);
                remember_word();
            end else if (sel < 70 && kw_cnt > 0) begin
                load_known();
                extra = $urandom_range(0, 3);
                for (int k = 0; k < extra; k++) begin
                    word_buf[word_n] = pick_char();
                    word_n++;
                end
                queue_word(REQ_LOOKUP, 1);
            end else if (sel < 80 && kw_cnt > 0) begin
                load_known();
                word_n = $urandom_range(1, word_n);
                if ($urandom_range(0, 1))
                    word_buf[$urandom_range(0, word_n - 1)] = pick_char();
                queue_word(REQ_LOOKUP, 1);
            end else if (sel < 92) begin
                word_n = $urandom_range(1, 8);
                for (int k = 0; k < word_n; k++)
                    word_buf[k] = pick_char();
                queue_word(REQ_LOOKUP, 1);
            end else begin
                // broken sequences: any kind, random ends
                repeat ($urandom_range(1, 4))
                    put(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        $urandom_range(0, 2) == 0, 16'($urandom_range(0, 65535)));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_q.size() != 0 || holding || answer_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("trie_keyword_matcher test passed");
        else
            $display("trie_keyword_matcher test failed");
        $finish;
    end

endmodule
